// File: src/assert_macros.svh
// assertion macros shared by the monitor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define SAM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sedentary monitor assertion failed");
// expression must never be true out of reset
`define SAM_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("sedentary monitor forbidden condition seen");
`else
`define SAM_ASSERT(lbl, clk, rst, prop)
`define SAM_NEVER(lbl, clk, rst, expr)
`endif

`endif

// File: src/sam_pkg.sv
// types and constants of the sedentary alert monitor
`default_nettype none

package sam_pkg;

  localparam int unsigned WINDOW_LEN_DEF = 5;

  localparam logic [15:0] IDLE_SUM_LIMIT = 16'd13;
  localparam logic [7:0]  IDLE_COUNT_MAX = 8'd245;
  localparam logic [7:0]  THR_MIN        = 8'd30;
  localparam logic [7:0]  THR_MAX        = 8'd240;
  localparam logic [11:0] START_MAX      = 12'(17 * 60 + 30);
  localparam logic [11:0] START_MIN      = 12'(8 * 60);
  localparam logic [11:0] END_MAX        = 12'(18 * 60);
  localparam logic [11:0] END_MIN        = 12'(8 * 60 + 30);
  localparam logic [2:0]  WEAR_WORN_LIM  = 3'd2;
  localparam logic [2:0]  WEAR_WORN_ALT  = 3'd5;

  // register indexes of the configuration port
  localparam logic [2:0] REG_ENABLE       = 3'd0;
  localparam logic [2:0] REG_THRESHOLD    = 3'd1;
  localparam logic [2:0] REG_START_HOUR   = 3'd2;
  localparam logic [2:0] REG_START_MINUTE = 3'd3;
  localparam logic [2:0] REG_END_HOUR     = 3'd4;
  localparam logic [2:0] REG_END_MINUTE   = 3'd5;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] total_steps;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        signed_off;
    logic        sleeping;
    logic        pwr_good;
    logic [2:0]  wear_state;
  } in_t;

  typedef struct packed {
    logic        alert;
    logic        config_valid;
    logic [15:0] window_sum;
    logic [7:0]  sit_count;
  } out_t;

  typedef struct packed {
    logic [7:0] enable;
    logic [7:0] threshold_minutes;
    logic [4:0] start_hour;
    logic [5:0] start_minute;
    logic [4:0] end_hour;
    logic [5:0] end_minute;
  } cfg_t;

  // per-transaction control from the top level to the state holders
  typedef struct packed {
    logic step;     // a transaction moves into the result register
    logic restart;  // that transaction is a restart command
    logic push;     // that transaction is a qualified tick
  } ctl_t;

endpackage

`default_nettype wire

// File: src/sam_cfg.sv
// configuration registers and the configuration range check
`default_nettype none

module sam_cfg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire logic [2:0]      wr_index,
  input  wire logic [7:0]      wr_data,
  output sam_pkg::cfg_t        cfg,
  output logic                 cfg_ok
);

  logic [11:0] st_min;
  logic [11:0] en_min;
  logic [11:0] st_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable            <= 8'd0;
      cfg.threshold_minutes <= 8'd60;
      cfg.start_hour        <= 5'd8;
      cfg.start_minute      <= 6'd0;
      cfg.end_hour          <= 5'd18;
      cfg.end_minute        <= 6'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        sam_pkg::REG_ENABLE:       cfg.enable            <= wr_data;
        sam_pkg::REG_THRESHOLD:    cfg.threshold_minutes <= wr_data;
        sam_pkg::REG_START_HOUR:   cfg.start_hour        <= wr_data[4:0];
        sam_pkg::REG_START_MINUTE: cfg.start_minute      <= wr_data[5:0];
        sam_pkg::REG_END_HOUR:     cfg.end_hour          <= wr_data[4:0];
        sam_pkg::REG_END_MINUTE:   cfg.end_minute        <= wr_data[5:0];
        default: ;
      endcase
    end
  end

  // minutes since midnight, hour * 60 as a constant multiply
  assign st_min = 12'(cfg.start_hour) * 12'd60 + 12'(cfg.start_minute);
  assign en_min = 12'(cfg.end_hour) * 12'd60 + 12'(cfg.end_minute);
  assign st_thr = st_min + 12'(cfg.threshold_minutes);

  assign cfg_ok = (cfg.enable <= 8'd1) &&
                  (cfg.threshold_minutes >= sam_pkg::THR_MIN) &&
                  (cfg.threshold_minutes <= sam_pkg::THR_MAX) &&
                  (st_min <= sam_pkg::START_MAX) && (st_min >= sam_pkg::START_MIN) &&
                  (en_min <= sam_pkg::END_MAX) && (en_min >= sam_pkg::END_MIN) &&
                  (st_thr <= en_min);

endmodule

`default_nettype wire

// File: src/sam_window.sv
// step baseline, delta shift line and running window sum
`default_nettype none

module sam_window #(
  parameter int unsigned WINDOW_LEN = sam_pkg::WINDOW_LEN_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sam_pkg::ctl_t ctl,
  input  wire logic [31:0]   total_steps,
  output logic [15:0]        sum_next
);

  logic [31:0] baseline;
  logic [15:0] deltas [WINDOW_LEN];
  logic [15:0] sum;
  logic [15:0] delta;

  // unfilled entries hold zero, so the oldest tap is dropped even before the line is full
  assign delta = total_steps[15:0] - baseline[15:0];

  always_comb begin
    if (ctl.restart) begin
      sum_next = 16'd0;
    end else if (ctl.push) begin
      sum_next = sum + delta - deltas[0];
    end else begin
      sum_next = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline <= 32'd0;
      sum      <= 16'd0;
    end else if (ctl.step) begin
      sum <= sum_next;
      if (ctl.restart || ctl.push) begin
        baseline <= total_steps;
      end
    end
  end

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_tap
    always_ff @(posedge clk) begin
      if (rst) begin
        deltas[i] <= 16'd0;
      end else if (ctl.step) begin
        if (ctl.restart) begin
          deltas[i] <= 16'd0;
        end else if (ctl.push) begin
          if (i == WINDOW_LEN - 1) begin
            deltas[i] <= delta;
          end else begin
            deltas[i] <= deltas[(i + 1) % WINDOW_LEN];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/sam_idle.sv
// idle tick counter and alert decision
`default_nettype none

module sam_idle (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sam_pkg::ctl_t ctl,
  input  wire logic [15:0]   sum_next,
  input  wire logic [7:0]    threshold_minutes,
  output logic [7:0]         count_next,
  output logic               alert
);

  logic [7:0] count;
  logic [7:0] count_inc;

  assign count_inc = (count < sam_pkg::IDLE_COUNT_MAX) ? count + 8'd1 : count;

  always_comb begin
    alert      = 1'b0;
    count_next = 8'd0;
    if (!ctl.restart && ctl.push && (sum_next < sam_pkg::IDLE_SUM_LIMIT)) begin
      if (count_inc >= threshold_minutes) begin
        alert = 1'b1;
      end else begin
        count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 8'd0;
    end else if (ctl.step) begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// File: src/sedentary_alert_monitor.sv
// Sedentary alert monitor: one transaction per minute tick, one result transaction
// back for each. A transaction lands in an input register, passes one level of
// logic (qualification, step delta, running window sum, idle counter) and is
// caught in a result register, so the result is registered behind the input
// register, and the block takes one transaction every cycle as long as the
// result side keeps up; while a result waits, the transaction behind it holds in
// the input register and input stalls once that register is full.
// The window sum is kept as a running total (add the new delta, drop the oldest
// tap), so its cost does not grow with WINDOW_LEN. Configuration writes are
// taken in every cycle and act on the next tick; config_valid only reports the
// range check and never gates the monitor. No clearing pass after reset.
`default_nettype none

`include "assert_macros.svh"

module sedentary_alert_monitor #(
  parameter int unsigned WINDOW_LEN = sam_pkg::WINDOW_LEN_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // tick / restart transactions
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sam_pkg::in_t  in_data,
  // result transactions
  output logic               out_valid,
  input  wire logic          out_ready,
  output sam_pkg::out_t      out_data,
  // configuration writes
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [7:0]    cfg_data
);

  sam_pkg::in_t  in_q;
  logic          in_full;
  logic          advance;
  sam_pkg::cfg_t cfg;
  logic          cfg_ok;
  sam_pkg::ctl_t ctl;
  logic          worn;
  logic          qual;
  logic [10:0]   now_t;
  logic [10:0]   st_t;
  logic [10:0]   en_t;
  logic [15:0]   sum_next;
  logic [7:0]    count_next;
  logic          alert;

  // held transaction moves on when the result register is free or being drained
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  sam_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .cfg_ok   (cfg_ok)
  );

  // time window compare as hour then minute, i.e. {hour, minute} as one number
  assign now_t = {in_q.hour, in_q.minute};
  assign st_t  = {cfg.start_hour, cfg.start_minute};
  assign en_t  = {cfg.end_hour, cfg.end_minute};

  assign worn = (in_q.wear_state < sam_pkg::WEAR_WORN_LIM) ||
                (in_q.wear_state == sam_pkg::WEAR_WORN_ALT);

  assign qual = !in_q.signed_off && !in_q.sleeping && in_q.pwr_good && worn &&
                (cfg.enable != 8'd0) && (now_t >= st_t) && (now_t <= en_t);

  assign ctl.step    = advance;
  assign ctl.restart = (in_q.cmd == sam_pkg::CMD_RESTART);
  assign ctl.push    = (in_q.cmd == sam_pkg::CMD_TICK) && qual;

  sam_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .total_steps (in_q.total_steps),
    .sum_next    (sum_next)
  );

  sam_idle u_idle (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .sum_next          (sum_next),
    .threshold_minutes (cfg.threshold_minutes),
    .count_next        (count_next),
    .alert             (alert)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.alert        <= alert;
      out_data.config_valid <= cfg_ok;
      out_data.window_sum   <= sum_next;
      out_data.sit_count    <= count_next;
    end
  end

  // an alert always clears the idle counter
  `SAM_ASSERT(a_alert_clears, clk, rst, out_valid && out_data.alert |-> out_data.sit_count == 8'd0)
  // idle counter saturates
  `SAM_NEVER(a_count_sat, clk, rst, out_valid && (out_data.sit_count > sam_pkg::IDLE_COUNT_MAX))
  // a restart reports an empty window and zero count
  `SAM_ASSERT(a_restart_res, clk, rst, advance && in_q.cmd == sam_pkg::CMD_RESTART |=> out_valid && out_data.window_sum == 16'd0 && out_data.sit_count == 8'd0 && !out_data.alert)
  // an empty input register always takes a transaction
  `SAM_ASSERT(a_ready_empty, clk, rst, !in_full |-> in_ready)

endmodule

`default_nettype wire
